// File: src/rspe_pkg.sv
`timescale 1ns / 1ps

package rspe_pkg;

   // sizes
   localparam int MAX_ECC_LEN = 32;
   localparam int BYTE_W      = 8;
   localparam int CFG_W       = 6;
   localparam int LEN_W       = $clog2(MAX_ECC_LEN + 1);
   localparam int IDX_W       = $clog2(MAX_ECC_LEN);

   // field constants
   localparam logic [8:0]       GF_POLY       = 9'h11D;
   localparam logic [7:0]       GF_ROOT       = 8'h02;
   localparam logic [CFG_W-1:0] ECC_LEN_RESET = CFG_W'(10);

   // one byte per remainder / generator position, index 0 is the leading byte
   typedef logic [MAX_ECC_LEN-1:0][BYTE_W-1:0] byte_vec_type;

   // generator build sequencer
   typedef enum logic [1:0] {
      GEN_START,
      GEN_RUN,
      GEN_IDLE
   } gen_state_type;

   // generator status seen by the datapath
   typedef struct packed {
      logic             busy;
      logic             clear;
      logic [LEN_W-1:0] len;
   } gen_stat_type;

   // parity load request from the remainder stage to the output buffer
   typedef struct packed {
      logic             load;
      logic [LEN_W-1:0] len;
   } load_req_type;

   // GF(256) multiply, MSB first with reduction by 0x11D
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] z;
      z = 8'h00;
      for (int i = 7; i >= 0; i--) begin
         z = {z[6:0], 1'b0} ^ (z[7] ? GF_POLY[7:0] : 8'h00);
         if (b[i]) begin
            z = z ^ a;
         end
      end
      return z;
   endfunction

   // register value to parity length, clamped to 1..MAX_ECC_LEN
   function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return LEN_W'(1);
      end
      if (int'(v) > MAX_ECC_LEN) begin
         return LEN_W'(MAX_ECC_LEN);
      end
      return LEN_W'(v);
   endfunction

endpackage

// File: src/rspe_req_if.sv
`timescale 1ns / 1ps

interface rspe_req_if import rspe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              block_end;

   modport source (output valid, output data_byte, output block_end, input ready);
   modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

// File: src/rspe_rsp_if.sv
`timescale 1ns / 1ps

interface rspe_rsp_if import rspe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] parity_byte;
   logic              parity_last;

   modport source (output valid, output parity_byte, output parity_last, input ready);
   modport sink   (input valid, input parity_byte, input parity_last, output ready);
endinterface

// File: src/rspe_csr_if.sv
`timescale 1ns / 1ps

interface rspe_csr_if import rspe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] ecc_len;

   modport source (output valid, output ecc_len, input ready);
   modport sink   (input valid, input ecc_len, output ready);
endinterface

// File: src/rspe_gen.sv
`timescale 1ns / 1ps

// Generator polynomial builder: one root multiplied in per cycle.
module rspe_gen import rspe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rspe_csr_if.sink      csr_port,
   output gen_stat_type  stat,
   output byte_vec_type  gen_coeffs
);

   gen_state_type     state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [7:0]        root_ff, root_in;
   logic [IDX_W-1:0]  iter_ff, iter_in;
   byte_vec_type      gen_ff, gen_in;
   byte_vec_type      gen_up;
   logic [IDX_W-1:0]  len_m1;
   logic              csr_take;

   assign len_m1   = IDX_W'(len_ff - LEN_W'(1));
   assign csr_take = csr_port.valid && csr_port.ready;
   assign gen_up   = {8'h00, gen_ff[MAX_ECC_LEN-1:1]};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         GEN_START: state_in = GEN_RUN;
         GEN_RUN: begin
            if (iter_ff == len_m1) begin
               state_in = GEN_IDLE;
            end
         end
         GEN_IDLE: begin
            if (csr_port.valid) begin
               state_in = GEN_START;
            end
         end
         default: state_in = GEN_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      csr_port.ready = (state_ff == GEN_IDLE);
      stat.busy      = (state_ff != GEN_IDLE);
      stat.clear     = (state_ff == GEN_START);
      stat.len       = len_ff;
   end

   // coefficient update: g[j] = g[j]*root ^ g[j+1]
   always_comb begin
      len_in  = csr_take ? eff_len(csr_port.ecc_len) : len_ff;
      root_in = root_ff;
      iter_in = iter_ff;
      gen_in  = gen_ff;
      if (state_ff == GEN_START) begin
         root_in = 8'h01;
         iter_in = '0;
         for (int j = 0; j < MAX_ECC_LEN; j++) begin
            gen_in[j] = (IDX_W'(j) == len_m1) ? 8'h01 : 8'h00;
         end
      end else if (state_ff == GEN_RUN) begin
         root_in = gf_mul(root_ff, GF_ROOT);
         iter_in = iter_ff + IDX_W'(1);
         for (int j = 0; j < MAX_ECC_LEN; j++) begin
            gen_in[j] = gf_mul(gen_ff[j], root_ff) ^ gen_up[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEN_START;
         len_ff   <= eff_len(ECC_LEN_RESET);
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
      root_ff <= root_in;
      iter_ff <= iter_in;
      gen_ff  <= gen_in;
   end

   assign gen_coeffs = gen_ff;

endmodule

// File: src/rspe_lfsr.sv
`timescale 1ns / 1ps

// Input word register and parallel remainder update.
module rspe_lfsr import rspe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rspe_req_if.sink      req_port,
   input  gen_stat_type  stat,
   input  byte_vec_type  gen_coeffs,
   input  logic          out_free,
   output load_req_type  load_req,
   output byte_vec_type  parity_vec
);

   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_end_ff;
   byte_vec_type      rem_ff, rem_in;
   byte_vec_type      rem_up, rem_next;
   logic [7:0]        fb;
   logic              advance;
   logic              req_take;

   // a held last word waits until the output buffer can take the parity
   assign advance  = in_vld_ff && (!in_end_ff || out_free);
   assign req_port.ready = !stat.busy && (!in_vld_ff || advance);
   assign req_take = req_port.valid && req_port.ready;

   // one LFSR step over all taps
   assign fb     = in_byte_ff ^ rem_ff[0];
   assign rem_up = {8'h00, rem_ff[MAX_ECC_LEN-1:1]};
   always_comb begin
      for (int i = 0; i < MAX_ECC_LEN; i++) begin
         rem_next[i] = rem_up[i] ^ gf_mul(gen_coeffs[i], fb);
      end
   end

   always_comb begin
      rem_in = rem_ff;
      if (stat.clear) begin
         rem_in = '0;
      end else if (advance) begin
         rem_in = in_end_ff ? '0 : rem_next;
      end
   end

   assign in_vld_in     = req_take || (in_vld_ff && !advance);
   assign load_req.load = advance && in_end_ff;
   assign load_req.len  = stat.len;
   assign parity_vec    = rem_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         rem_ff    <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         rem_ff    <= rem_in;
      end
      if (req_take) begin
         in_byte_ff <= req_port.data_byte;
         in_end_ff  <= req_port.block_end;
      end
   end

endmodule

// File: src/rspe_out.sv
`timescale 1ns / 1ps

// Parity output buffer: loaded whole, shifted out one word per cycle on ready.
module rspe_out import rspe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  load_req_type  load_req,
   input  byte_vec_type  parity_vec,
   output logic          out_free,
   rspe_rsp_if.source    rsp_port
);

   byte_vec_type     par_ff, par_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic             rsp_take;

   assign rsp_take = rsp_port.valid && rsp_port.ready;
   assign out_free = (cnt_ff == '0) || ((cnt_ff == LEN_W'(1)) && rsp_port.ready);

   assign rsp_port.valid       = (cnt_ff != '0);
   assign rsp_port.parity_byte = par_ff[0];
   assign rsp_port.parity_last = (cnt_ff == LEN_W'(1));

   // load wins; it only happens when the last word is leaving or none is left
   always_comb begin
      par_in = par_ff;
      cnt_in = cnt_ff;
      if (load_req.load) begin
         par_in = parity_vec;
         cnt_in = load_req.len;
      end else if (rsp_take) begin
         par_in = {8'h00, par_ff[MAX_ECC_LEN-1:1]};
         cnt_in = cnt_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      par_ff <= par_in;
   end

endmodule

// File: src/reed_solomon_parity_encoder.sv
`timescale 1ns / 1ps

// Channel   Dir   Word                              Accepted when
// req_port  in    data_byte[7:0], block_end         valid && ready
// rsp_port  out   parity_byte[7:0], parity_last     valid && ready
// csr_port  in    ecc_len[5:0]                      valid && ready
//
// One data word per cycle unless stalled: the input register feeds a parallel
// LFSR, one GF(256) multiply per tap, and the whole remainder updates at once.
// A last word loads the remainder into the output buffer, which sends L words
// at one per cycle while rsp_port is ready; next block's data words flow in.
// A last word stalls only while the previous block's parity is still going out.
// After reset and after each ecc_len write the generator is rebuilt for L roots
// (L = clamped length, 10 after reset); req_port is not ready meanwhile.
module reed_solomon_parity_encoder import rspe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rspe_req_if.sink    req_port,
   rspe_rsp_if.source  rsp_port,
   rspe_csr_if.sink    csr_port
);

   gen_stat_type  stat;
   byte_vec_type  gen_coeffs;
   byte_vec_type  parity_vec;
   load_req_type  load_req;
   logic          out_free;

   rspe_gen u_gen (
      .clock      (clock),
      .reset      (reset),
      .csr_port   (csr_port),
      .stat       (stat),
      .gen_coeffs (gen_coeffs)
   );

   rspe_lfsr u_lfsr (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .stat       (stat),
      .gen_coeffs (gen_coeffs),
      .out_free   (out_free),
      .load_req   (load_req),
      .parity_vec (parity_vec)
   );

   rspe_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_req   (load_req),
      .parity_vec (parity_vec),
      .out_free   (out_free),
      .rsp_port   (rsp_port)
   );

   // a length write starts a rebuild, so no data word is taken next cycle
   assert property (@(posedge clock) disable iff (reset)
      csr_port.valid && csr_port.ready |=> !req_port.ready)
      else $error("data accepted right after ecc_len write");

   // parity is only loaded into a free output buffer
   assert property (@(posedge clock) disable iff (reset)
      load_req.load |-> out_free)
      else $error("parity load over pending output");

   // last parity word taken with no new block loaded empties the buffer
   assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.ready && rsp_port.parity_last && !load_req.load
      |=> !rsp_port.valid)
      else $error("output still valid after final parity word");

endmodule

// File: tb/tb_reed_solomon_parity_encoder.sv
`timescale 1ns / 1ps

module tb_reed_solomon_parity_encoder import rspe_pkg::*;;

   localparam int DRAIN_GAP  = 48;
   localparam int PLAN_ROWS  = 28;
   localparam int SET_WORDS  = 40;
   localparam int MAX_REPORT = 10;

   typedef enum logic {
      ROW_WORD,
      ROW_LEN
   } row_kind_type;

   // one directed step: a data word or an ecc_len write
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   val;
      logic         fin;
      logic         typed;
      logic [7:0]   want;
   } plan_row_type;

   typedef struct packed {
      logic [7:0] value;
      logic       fin;
   } parity_word_type;

   // directed steps; typed rows carry parity that is obvious by hand
   // (zero blocks give zero parity, a one-byte code is the XOR of the block)
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ROW_WORD, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'h00, 1'b1, 1'b1, 8'h00},
      '{ROW_WORD, 8'hFF, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'h80, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'h01, 1'b1, 1'b0, 8'h00},
      '{ROW_WORD, 8'hA5, 1'b1, 1'b0, 8'h00},
      // half a block, then a length change must drop it
      '{ROW_WORD, 8'h77, 1'b0, 1'b0, 8'h00},
      '{ROW_LEN,  8'h05, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'h00, 1'b1, 1'b1, 8'h00},
      // zero length acts as one parity byte
      '{ROW_LEN,  8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'hFF, 1'b1, 1'b1, 8'hFF},
      '{ROW_WORD, 8'h0F, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'hF0, 1'b1, 1'b1, 8'hFF},
      '{ROW_WORD, 8'h55, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'h55, 1'b1, 1'b1, 8'h00},
      // all-ones length saturates to the maximum
      '{ROW_LEN,  8'h3F, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'hFF, 1'b1, 1'b0, 8'h00},
      '{ROW_WORD, 8'h00, 1'b1, 1'b1, 8'h00},
      '{ROW_LEN,  8'h20, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'h12, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'h34, 1'b1, 1'b0, 8'h00},
      '{ROW_LEN,  8'h21, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'hC3, 1'b1, 1'b0, 8'h00},
      '{ROW_LEN,  8'h01, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'h80, 1'b1, 1'b1, 8'h80},
      '{ROW_LEN,  8'h02, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'h01, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 8'hFE, 1'b1, 1'b0, 8'h00}
   };

   // lengths per random setting; the last of each phase is drawn at random
   localparam logic [CFG_W-1:0] LEN_PLAN [12] = '{
      6'd1,  6'd32, 6'd0,  6'd0,
      6'd63, 6'd2,  6'd17, 6'd0,
      6'd33, 6'd10, 6'd31, 6'd0
   };

   logic clock;
   logic reset;

   rspe_req_if req_if ();
   rspe_rsp_if rsp_if ();
   rspe_csr_if csr_if ();

   reed_solomon_parity_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // encoder state mirror
   logic [7:0]      gen_coef [MAX_ECC_LEN];
   logic [7:0]      rem_byte [MAX_ECC_LEN];
   int unsigned     par_len;
   parity_word_type parity_due [$];

   int unsigned src_idle_pct;
   int unsigned sink_idle_pct;
   int unsigned fault_count = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   // run limit
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // GF(256) product, LSB first, reduced by 0x11D
   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] p;
      acc = 8'h00;
      p   = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ p;
         end
         p = {p[6:0], 1'b0} ^ (p[7] ? GF_POLY[7:0] : 8'h00);
      end
      return acc;
   endfunction

   // new length: clamp, rebuild generator, clear remainder
   function automatic void load_length(input logic [CFG_W-1:0] v);
      logic [7:0] poly [MAX_ECC_LEN+1];
      logic [7:0] root;
      if (v == '0) begin
         par_len = 1;
      end else if (int'(v) > MAX_ECC_LEN) begin
         par_len = MAX_ECC_LEN;
      end else begin
         par_len = int'(v);
      end
      for (int k = 0; k <= MAX_ECC_LEN; k++) begin
         poly[k] = 8'h00;
      end
      // poly[k] is the x^k coefficient; multiply in (x + 2^i)
      poly[0] = 8'h01;
      root    = 8'h01;
      for (int i = 0; i < par_len; i++) begin
         for (int k = par_len; k > 0; k--) begin
            poly[k] = poly[k-1] ^ gf_times(poly[k], root);
         end
         poly[0] = gf_times(poly[0], root);
         root    = gf_times(root, GF_ROOT);
      end
      // stored highest power first, leading 1 dropped
      for (int j = 0; j < MAX_ECC_LEN; j++) begin
         gen_coef[j] = (j < par_len) ? poly[par_len-1-j] : 8'h00;
         rem_byte[j] = 8'h00;
      end
   endfunction

   // one accepted data word; a last word queues the parity words
   function automatic void encode_word(input logic [7:0] b, input logic fin,
                                       input logic typed, input logic [7:0] want);
      logic [7:0] fb;
      fb = b ^ rem_byte[0];
      for (int i = 0; i < MAX_ECC_LEN; i++) begin
         rem_byte[i] = (i + 1 < par_len) ? rem_byte[i+1] : 8'h00;
      end
      for (int i = 0; i < par_len; i++) begin
         rem_byte[i] = rem_byte[i] ^ gf_times(gen_coef[i], fb);
      end
      if (fin) begin
         for (int i = 0; i < par_len; i++) begin
            parity_due.insert(parity_due.size(),
               parity_word_type'{typed ? want : rem_byte[i], i == par_len - 1});
         end
         for (int i = 0; i < MAX_ECC_LEN; i++) begin
            rem_byte[i] = 8'h00;
         end
      end
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic log_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORT) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // drive one data word, with random gaps ahead of it
   task automatic send_word(input logic [7:0] b, input logic fin,
                            input logic typed, input logic [7:0] want);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.block_end <= fin;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      encode_word(b, fin, typed, want);
   endtask

   // hold the sender until every parity word is out
   task automatic await_drain();
      req_if.valid <= 1'b0;
      while (parity_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ecc_len write, only with the encoder quiet
   task automatic write_length(input logic [CFG_W-1:0] v);
      await_drain();
      repeat (DRAIN_GAP) @(posedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.ecc_len <= v;
      do begin
         @(posedge clock);
      end while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      load_length(v);
   endtask

   // parity sink: check each accepted word, then pick next ready
   always @(posedge clock) begin
      parity_word_type due;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (parity_due.size() == 0) begin
               log_fault($sformatf("unexpected parity word %02h last %0b",
                                   rsp_if.parity_byte, rsp_if.parity_last));
            end else begin
               due = parity_due.pop_front();
               if (rsp_if.parity_byte !== due.value || rsp_if.parity_last !== due.fin) begin
                  log_fault($sformatf("parity word: expected %02h last %0b, got %02h last %0b",
                                      due.value, due.fin, rsp_if.parity_byte,
                                      rsp_if.parity_last));
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // stimulus
   initial begin
      int unsigned      sent;
      int unsigned      blen;
      logic [CFG_W-1:0] v;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.block_end = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.ecc_len   = '0;
      src_idle_pct     = 19;
      sink_idle_pct    = 86;
      load_length(ECC_LEN_RESET);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed steps
      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].kind == ROW_LEN) begin
            write_length(PLAN[r].val[CFG_W-1:0]);
         end else begin
            send_word(PLAN[r].val, PLAN[r].fin, PLAN[r].typed, PLAN[r].want);
         end
      end

      // random blocks: three idle phases, four lengths each
      for (int ph = 0; ph < 3; ph++) begin
         src_idle_pct  = (ph == 0) ? 19 : (ph == 1) ? 86 : 0;
         sink_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 19 : 0;
         for (int k = 0; k < 4; k++) begin
            v = (k == 3) ? CFG_W'($urandom_range(63)) : LEN_PLAN[ph*4+k];
            write_length(v);
            sent = 0;
            while (sent < SET_WORDS) begin
               // mostly short blocks, now and then a long one
               blen = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
               for (int b = 0; b < blen; b++) begin
                  send_word(rand_byte(), b == blen - 1, 1'b0, 8'h00);
                  sent++;
               end
               if (k == 1 && sent >= SET_WORDS / 2 && sent < SET_WORDS / 2 + blen) begin
                  await_drain();
               end
            end
            // sometimes leave a block open for the next length change to drop
            if ($urandom_range(3) == 0) begin
               repeat ($urandom_range(1, 3)) send_word(rand_byte(), 1'b0, 1'b0, 8'h00);
            end
         end
      end

      await_drain();
      repeat (DRAIN_GAP) @(posedge clock);
      if (fault_count == 0 && parity_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
